### rtl/sbc_pkg.sv
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int MAG_WIDTH   = COORD_WIDTH;
  localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int STAGES      = 5;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_X      = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_Y      = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_Z      = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPHERE_RADIUS = 2'd3;

  localparam logic MODE_BOX    = 1'b0;
  localparam logic MODE_SPHERE = 1'b1;

  typedef enum logic [1:0] {
    REL_OUTSIDE    = 2'd0,
    REL_INTERSECTS = 2'd1,
    REL_INSIDE     = 2'd2
  } rel_t;

  // |a - b| of two signed coordinates; always fits MAG_WIDTH bits unsigned
  function automatic logic [MAG_WIDTH-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                                     input logic [COORD_WIDTH-1:0] b);
    logic [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0] m;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    m = d[COORD_WIDTH] ? (~d + 1'b1) : d;
    return m[MAG_WIDTH-1:0];
  endfunction

endpackage

### rtl/sphere_bounds_classifier.sv
`timescale 1ns / 1ps

// Sphere bounds classifier: tests a box or another sphere against the
// reference sphere held in the configuration registers.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0..2 center x/y/z, 3 radius). Write only while the pipeline is empty.
// Input channel (in_valid/in_ready): one query per beat; in_mode selects
// box (0) or sphere (1) and the fields of the other kind are ignored.
// Result channel (out_valid/out_ready): one beat of out_relation per query,
// 0 outside, 1 intersects, 2 inside, in query order.
// Path: each query passes the input register, offsets, squares, sums and
// result register in that order before out_valid rises.
// Throughput: one query per cycle while out_ready is high, set by the five-stage
// pipeline in which each stage holds at most one query.
// Stall: when out_ready is low the result holds and queries pile up in
// the empty stages behind it; in_ready drops only once every stage is full.
// Reset: all stages empty and the configuration registers cleared to zero.

module sphere_bounds_classifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sbc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_min_x,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_min_y,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_min_z,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_max_x,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_max_y,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_box_max_z,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_other_x,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_other_y,
  input  logic [sbc_pkg::COORD_WIDTH-1:0]      in_other_z,
  input  logic [sbc_pkg::RAD_WIDTH-1:0]        in_other_radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_relation
);

  // configuration
  logic [sbc_pkg::COORD_WIDTH-1:0] center_r [3];
  logic [sbc_pkg::RAD_WIDTH-1:0]   radius_r;

  // pipeline control
  logic [sbc_pkg::STAGES-1:0] valid_r;
  logic [sbc_pkg::STAGES-1:0] valid_nxt;
  logic [sbc_pkg::STAGES-1:0] adv;

  // stage 0: input register
  logic                            s0_mode_r;
  logic [sbc_pkg::COORD_WIDTH-1:0] s0_min_r   [3];
  logic [sbc_pkg::COORD_WIDTH-1:0] s0_max_r   [3];
  logic [sbc_pkg::COORD_WIDTH-1:0] s0_other_r [3];
  logic [sbc_pkg::RAD_WIDTH-1:0]   s0_orad_r;

  // stage 1: offsets
  logic                          s1_mode_r;
  logic                          s1_rgt_r;
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_main_r   [3];
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_corner_r [6];
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_rad_r;
  logic                          s1_rgt_nxt;
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_main_nxt   [3];
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_corner_nxt [6];
  logic [sbc_pkg::MAG_WIDTH-1:0] s1_rad_nxt;

  // stage 2: squares
  logic                         s2_mode_r;
  logic                         s2_rgt_r;
  logic [sbc_pkg::SQ_WIDTH-1:0] s2_main_r   [3];
  logic [sbc_pkg::SQ_WIDTH-1:0] s2_corner_r [6];
  logic [sbc_pkg::SQ_WIDTH-1:0] s2_rad_r;

  // stage 3: sums
  logic                          s3_mode_r;
  logic                          s3_rgt_r;
  logic [sbc_pkg::SUM_WIDTH-1:0] s3_near_r;
  logic [sbc_pkg::SUM_WIDTH-1:0] s3_far_r;
  logic [sbc_pkg::SQ_WIDTH-1:0]  s3_rr_r;
  logic [sbc_pkg::SQ_WIDTH-1:0]  s3_rin_r;
  logic [sbc_pkg::SUM_WIDTH-1:0] s3_near_nxt;
  logic [sbc_pkg::SUM_WIDTH-1:0] s3_far_nxt;

  // stage 4: result
  sbc_pkg::rel_t rel_r;
  sbc_pkg::rel_t rel_nxt;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        center_r[i] <= '0;
      end
      radius_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbc_pkg::CFG_CENTER_X:      center_r[0] <= cfg_data;
        sbc_pkg::CFG_CENTER_Y:      center_r[1] <= cfg_data;
        sbc_pkg::CFG_CENTER_Z:      center_r[2] <= cfg_data;
        sbc_pkg::CFG_SPHERE_RADIUS: radius_r    <= cfg_data[sbc_pkg::RAD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline flow: a stage advances when it is empty or the next one moves
  // ---------------------------------------------------------------------
  always_comb begin
    adv[sbc_pkg::STAGES-1] = !valid_r[sbc_pkg::STAGES-1] || out_ready;
    for (int k = sbc_pkg::STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
    valid_nxt[0] = adv[0] ? in_valid : valid_r[0];
    for (int k = 1; k < sbc_pkg::STAGES; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready     = adv[0];
  assign out_valid    = valid_r[sbc_pkg::STAGES-1];
  assign out_relation = rel_r;

  // ---------------------------------------------------------------------
  // stage 0: capture the beat
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_mode_r     <= in_mode;
      s0_min_r[0]   <= in_box_min_x;
      s0_min_r[1]   <= in_box_min_y;
      s0_min_r[2]   <= in_box_min_z;
      s0_max_r[0]   <= in_box_max_x;
      s0_max_r[1]   <= in_box_max_y;
      s0_max_r[2]   <= in_box_max_z;
      s0_other_r[0] <= in_other_x;
      s0_other_r[1] <= in_other_y;
      s0_other_r[2] <= in_other_z;
      s0_orad_r     <= in_other_radius;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: per-axis offsets and radius terms
  // ---------------------------------------------------------------------
  always_comb begin
    s1_rgt_nxt = radius_r > s0_orad_r;
    for (int i = 0; i < 3; i++) begin
      s1_corner_nxt[2*i]   = sbc_pkg::abs_diff(s0_min_r[i], center_r[i]);
      s1_corner_nxt[2*i+1] = sbc_pkg::abs_diff(s0_max_r[i], center_r[i]);
      if (s0_mode_r == sbc_pkg::MODE_SPHERE) begin
        s1_main_nxt[i] = sbc_pkg::abs_diff(s0_other_r[i], center_r[i]);
      end else if ($signed(center_r[i]) < $signed(s0_min_r[i])) begin
        s1_main_nxt[i] = sbc_pkg::abs_diff(s0_min_r[i], center_r[i]);
      end else if ($signed(center_r[i]) > $signed(s0_max_r[i])) begin
        s1_main_nxt[i] = sbc_pkg::abs_diff(center_r[i], s0_max_r[i]);
      end else begin
        s1_main_nxt[i] = '0;
      end
    end
    // sphere mode reuses the first corner slot for r - other_radius
    if (s0_mode_r == sbc_pkg::MODE_SPHERE) begin
      s1_corner_nxt[0] = s1_rgt_nxt ? {1'b0, radius_r - s0_orad_r} : '0;
      s1_rad_nxt       = {1'b0, radius_r} + {1'b0, s0_orad_r};
    end else begin
      s1_rad_nxt       = {1'b0, radius_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_mode_r   <= s0_mode_r;
      s1_rgt_r    <= s1_rgt_nxt;
      for (int i = 0; i < 3; i++) begin
        s1_main_r[i] <= s1_main_nxt[i];
      end
      for (int j = 0; j < 6; j++) begin
        s1_corner_r[j] <= s1_corner_nxt[j];
      end
      s1_rad_r    <= s1_rad_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: squares
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_mode_r <= s1_mode_r;
      s2_rgt_r  <= s1_rgt_r;
      for (int i = 0; i < 3; i++) begin
        s2_main_r[i] <= s1_main_r[i] * s1_main_r[i];
      end
      for (int j = 0; j < 6; j++) begin
        s2_corner_r[j] <= s1_corner_r[j] * s1_corner_r[j];
      end
      s2_rad_r <= s1_rad_r * s1_rad_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: near distance and farthest corner distance
  // ---------------------------------------------------------------------
  always_comb begin
    s3_near_nxt = '0;
    s3_far_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      s3_near_nxt = s3_near_nxt + sbc_pkg::SUM_WIDTH'(s2_main_r[i]);
      if (s2_corner_r[2*i] > s2_corner_r[2*i+1]) begin
        s3_far_nxt = s3_far_nxt + sbc_pkg::SUM_WIDTH'(s2_corner_r[2*i]);
      end else begin
        s3_far_nxt = s3_far_nxt + sbc_pkg::SUM_WIDTH'(s2_corner_r[2*i+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_mode_r <= s2_mode_r;
      s3_rgt_r  <= s2_rgt_r;
      s3_near_r <= s3_near_nxt;
      s3_far_r  <= s3_far_nxt;
      s3_rr_r   <= s2_rad_r;
      s3_rin_r  <= s2_corner_r[0];
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: classify
  // ---------------------------------------------------------------------
  always_comb begin
    if (s3_near_r >= sbc_pkg::SUM_WIDTH'(s3_rr_r)) begin
      rel_nxt = sbc_pkg::REL_OUTSIDE;
    end else if (s3_mode_r == sbc_pkg::MODE_SPHERE) begin
      if (s3_rgt_r && (s3_near_r < sbc_pkg::SUM_WIDTH'(s3_rin_r))) begin
        rel_nxt = sbc_pkg::REL_INSIDE;
      end else begin
        rel_nxt = sbc_pkg::REL_INTERSECTS;
      end
    end else if (s3_far_r >= sbc_pkg::SUM_WIDTH'(s3_rr_r)) begin
      rel_nxt = sbc_pkg::REL_INTERSECTS;
    end else begin
      rel_nxt = sbc_pkg::REL_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rel_r <= rel_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a full stage that is held must still be full next cycle
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((valid_r & $past(~adv)) == ($past(valid_r) & $past(~adv))))
    else $error("pipeline stage lost a query while stalled");

  // a draining output never back-pressures the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output drains");

  // near distance at or beyond the outer radius (radius sum for spheres) must classify as outside
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[3] && adv[4] && (s3_near_r >= sbc_pkg::SUM_WIDTH'(s3_rr_r)))
    |=> (out_valid && out_relation == sbc_pkg::REL_OUTSIDE))
    else $error("far query not reported outside");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CW = sbc_pkg::COORD_WIDTH;
  localparam int RW = sbc_pkg::RAD_WIDTH;

  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] HALF = 32'h0000_8000;
  localparam logic [CW-1:0] QTR  = 32'h0000_4000;
  localparam logic [CW-1:0] CMIN = 32'h8000_0000;
  localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
  localparam logic [RW-1:0] RMAX = '1;

  typedef struct packed {
    logic                  mode;
    logic [2:0][CW-1:0]    box_lo;
    logic [2:0][CW-1:0]    box_hi;
    logic [2:0][CW-1:0]    oth;
    logic [RW-1:0]         orad;
  } query_t;

  typedef struct packed {
    logic [2:0][CW-1:0]    center;
    logic [RW-1:0]         radius;
  } sphere_t;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_CFG,
    OP_DRAIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    query_t                q;
    logic [sbc_pkg::CFG_IDX_WIDTH-1:0] idx;
    logic [CW-1:0]         val;
  } op_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [sbc_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CW-1:0]            cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_mode = 1'b0;
  logic [CW-1:0]            in_box_min_x = '0;
  logic [CW-1:0]            in_box_min_y = '0;
  logic [CW-1:0]            in_box_min_z = '0;
  logic [CW-1:0]            in_box_max_x = '0;
  logic [CW-1:0]            in_box_max_y = '0;
  logic [CW-1:0]            in_box_max_z = '0;
  logic [CW-1:0]            in_other_x = '0;
  logic [CW-1:0]            in_other_y = '0;
  logic [CW-1:0]            in_other_z = '0;
  logic [RW-1:0]            in_other_radius = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_relation;

  op_t           ops[$];
  sbc_pkg::rel_t pending_rel[$];
  sphere_t     ref_sphere = '0;
  sphere_t     plan_sphere = '0;
  logic        query_taken = 1'b0;
  logic        quiet = 1'b0;
  int unsigned quiet_left = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;

  sphere_bounds_classifier u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_box_min_x    (in_box_min_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_min_z    (in_box_min_z),
    .in_box_max_x    (in_box_max_x),
    .in_box_max_y    (in_box_max_y),
    .in_box_max_z    (in_box_max_z),
    .in_other_x      (in_other_x),
    .in_other_y      (in_other_y),
    .in_other_z      (in_other_z),
    .in_other_radius (in_other_radius),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_relation    (out_relation)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // |a - b| of two signed coordinates
  function automatic logic [CW:0] abs_off(logic [CW-1:0] a, logic [CW-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (CW+1)'((d < 0) ? -d : d);
  endfunction

  function automatic logic [2*CW+1:0] sq(logic [CW:0] x);
    logic [2*CW+1:0] w;
    w = (2*CW+2)'(x);
    return w * w;
  endfunction

  function automatic sbc_pkg::rel_t classify(query_t q, sphere_t s);
    logic [2*CW+1:0] near_sum;
    logic [2*CW+1:0] far_sum;
    logic [2*CW+1:0] a;
    logic [2*CW+1:0] b;
    logic [CW:0]     rsum;
    logic [CW:0]     rdif;
    near_sum = '0;
    far_sum  = '0;
    if (q.mode == sbc_pkg::MODE_BOX) begin
      for (int i = 0; i < 3; i++) begin
        // clamp: below min is tested before above max, so an inverted box clamps to min when the center is below min
        if ($signed(s.center[i]) < $signed(q.box_lo[i]))
          near_sum += sq(abs_off(s.center[i], q.box_lo[i]));
        else if ($signed(s.center[i]) > $signed(q.box_hi[i]))
          near_sum += sq(abs_off(s.center[i], q.box_hi[i]));
        a = sq(abs_off(q.box_lo[i], s.center[i]));
        b = sq(abs_off(q.box_hi[i], s.center[i]));
        far_sum += (a > b) ? a : b;
      end
      if (near_sum >= sq((CW+1)'(s.radius))) return sbc_pkg::REL_OUTSIDE;
      if (far_sum >= sq((CW+1)'(s.radius))) return sbc_pkg::REL_INTERSECTS;
      return sbc_pkg::REL_INSIDE;
    end
    for (int i = 0; i < 3; i++)
      near_sum += sq(abs_off(q.oth[i], s.center[i]));
    rsum = (CW+1)'(s.radius) + (CW+1)'(q.orad);
    rdif = (CW+1)'(s.radius) - (CW+1)'(q.orad);
    if (near_sum >= sq(rsum)) return sbc_pkg::REL_OUTSIDE;
    if (s.radius > q.orad && near_sum < sq(rdif)) return sbc_pkg::REL_INSIDE;
    return sbc_pkg::REL_INTERSECTS;
  endfunction

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CW-1:0] near(logic [CW-1:0] c, int unsigned span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic query_t random_fill();
    query_t q;
    q.mode   = 1'($urandom_range(0, 1));
    q.box_lo = {$urandom, $urandom, $urandom};
    q.box_hi = {$urandom, $urandom, $urandom};
    q.oth    = {$urandom, $urandom, $urandom};
    q.orad   = RW'($urandom);
    return q;
  endfunction

  function automatic query_t box_q(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                                   logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
    query_t q;
    q = random_fill();
    q.mode   = sbc_pkg::MODE_BOX;
    q.box_lo = {lz, ly, lx};
    q.box_hi = {hz, hy, hx};
    return q;
  endfunction

  function automatic query_t ball_q(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                                    logic [RW-1:0] r);
    query_t q;
    q = random_fill();
    q.mode = sbc_pkg::MODE_SPHERE;
    q.oth  = {z, y, x};
    q.orad = r;
    return q;
  endfunction

  // volumes scattered around the reference sphere, mostly at a scale tied to its radius; one in ten is fully random
  function automatic query_t shaped_query(sphere_t plan);
    query_t          q;
    longint unsigned sp;
    int unsigned     span;
    q = random_fill();
    if ($urandom_range(0, 9) == 0) return q;
    sp = longint'(plan.radius) + 1;
    case ($urandom_range(0, 3))
      0: sp = sp / 4 + 1;
      1: sp = sp;
      2: sp = sp * 2;
      default: sp = longint'(1) << $urandom_range(0, 31);
    endcase
    if (sp > 64'h7fff_ffff) sp = 64'h7fff_ffff;
    span = 32'(sp);
    for (int i = 0; i < 3; i++) begin
      q.box_lo[i] = near(plan.center[i], span);
      if ($urandom_range(0, 9) == 0)
        q.box_hi[i] = q.box_lo[i] - $urandom_range(0, span);
      else
        q.box_hi[i] = q.box_lo[i] + $urandom_range(0, span);
      q.oth[i] = near(plan.center[i], span);
    end
    q.orad = RW'($urandom_range(0, span));
    return q;
  endfunction

  task automatic push_query(query_t q);
    op_t o;
    o = '0;
    o.kind = OP_QUERY;
    o.q = q;
    ops.push_back(o);
  endtask

  task automatic push_drain();
    op_t o;
    o = '0;
    o.kind = OP_DRAIN;
    ops.push_back(o);
  endtask

  task automatic push_cfg(logic [sbc_pkg::CFG_IDX_WIDTH-1:0] idx, logic [CW-1:0] val);
    op_t o;
    o = '0;
    o.kind = OP_CFG;
    o.idx = idx;
    o.val = val;
    ops.push_back(o);
  endtask

  task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                            logic [RW-1:0] r);
    push_cfg(sbc_pkg::CFG_CENTER_X, cx);
    push_cfg(sbc_pkg::CFG_CENTER_Y, cy);
    push_cfg(sbc_pkg::CFG_CENTER_Z, cz);
    // top data bit is outside the radius register; toggle it anyway
    push_cfg(sbc_pkg::CFG_SPHERE_RADIUS, {1'($urandom_range(0, 1)), r});
    plan_sphere.center = {cz, cy, cx};
    plan_sphere.radius = r;
  endtask

  // sender: hold a beat until taken, else gap, send next query, or write config or drain once no result is pending
  always @(negedge clk) begin : feed_queries
    logic nv;
    logic nwe;
    op_t  o;
    nv  = 1'b0;
    nwe = 1'b0;
    if (rst_n) begin
      if (in_valid && !query_taken) begin
        nv = 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
      end else if (ops.size() != 0) begin
        o = ops[0];
        if (o.kind == OP_QUERY) begin
          void'(ops.pop_front());
          in_mode         <= o.q.mode;
          in_box_min_x    <= o.q.box_lo[0];
          in_box_min_y    <= o.q.box_lo[1];
          in_box_min_z    <= o.q.box_lo[2];
          in_box_max_x    <= o.q.box_hi[0];
          in_box_max_y    <= o.q.box_hi[1];
          in_box_max_z    <= o.q.box_hi[2];
          in_other_x      <= o.q.oth[0];
          in_other_y      <= o.q.oth[1];
          in_other_z      <= o.q.oth[2];
          in_other_radius <= o.q.orad;
          nv = 1'b1;
          send_gap = pick_gap();
        end else if (pending_rel.size() == 0) begin
          void'(ops.pop_front());
          if (o.kind == OP_CFG) begin
            nwe = 1'b1;
            cfg_index <= o.idx;
            cfg_data  <= o.val;
          end
        end
      end
    end
    in_valid <= nv;
    cfg_we   <= nwe;
  end

  always @(negedge clk) begin : pace_results
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // alternate noisy and quiet stretches on both sides
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      quiet <= ~quiet;
      quiet_left = $urandom_range(50, 300);
    end else begin
      quiet_left--;
    end
  end

  always @(posedge clk) begin : watch_beats
    query_t        q;
    sbc_pkg::rel_t want;
    if (!rst_n) begin
      query_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbc_pkg::CFG_CENTER_X:      ref_sphere.center[0] = cfg_data;
          sbc_pkg::CFG_CENTER_Y:      ref_sphere.center[1] = cfg_data;
          sbc_pkg::CFG_CENTER_Z:      ref_sphere.center[2] = cfg_data;
          sbc_pkg::CFG_SPHERE_RADIUS: ref_sphere.radius    = cfg_data[RW-1:0];
          default: ;
        endcase
      end
      query_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        q.mode   = in_mode;
        q.box_lo = {in_box_min_z, in_box_min_y, in_box_min_x};
        q.box_hi = {in_box_max_z, in_box_max_y, in_box_max_x};
        q.oth    = {in_other_z, in_other_y, in_other_x};
        q.orad   = in_other_radius;
        pending_rel.push_back(classify(q, ref_sphere));
      end
      if (out_valid && out_ready) begin
        if (pending_rel.size() == 0) begin
          $display("%0t: relation beat %0d with no query outstanding", $time, out_relation);
          errors++;
        end else begin
          want = pending_rel.pop_front();
          if (out_relation !== want) begin
            $display("%0t: relation mismatch: expected %0d, actual %0d",
                     $time, want, out_relation);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [2:0][CW-1:0] c;
    logic [RW-1:0]      r;

    // zero radius after reset: the box and the point ball are outside, the ball around the center intersects
    push_query(box_q(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    push_query(ball_q('0, '0, '0, '0));
    push_query(ball_q('0, '0, '0, RW'(ONE)));

    set_sphere('0, '0, '0, RW'(ONE));
    push_query(box_q(-QTR, -QTR, -QTR, QTR, QTR, QTR));
    push_query(box_q(ONE, '0, '0, 2 * ONE, ONE, ONE));
    push_query(box_q(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
    push_query(box_q('0, '0, '0, ONE, '0, '0));
    push_query(box_q('0, '0, '0, ONE - 1, '0, '0));
    push_query(box_q(QTR, QTR, QTR, -QTR, -QTR, -QTR));
    push_query(box_q(-QTR, -QTR, -QTR, -HALF, -HALF, -HALF));
    push_query(ball_q('0, '0, '0, '0));
    push_query(ball_q(2 * ONE, '0, '0, RW'(ONE)));
    push_query(ball_q(HALF, '0, '0, RW'(HALF)));
    push_query(ball_q('0, '0, '0, RW'(2 * ONE)));
    push_query(ball_q('0, '0, '0, RW'(ONE)));
    push_query(box_q(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    push_query(ball_q(CMIN, CMIN, CMIN, RMAX));

    set_sphere(CMIN, CMAX, CMIN, RMAX);
    push_query(box_q(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    push_query(ball_q(CMAX, CMIN, CMAX, RMAX));
    push_query(ball_q(CMIN, CMAX, CMIN, '0));
    push_query(box_q(CMIN, CMAX, CMIN, CMIN, CMAX, CMIN));
    push_query(box_q(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));

    for (int p = 0; p < 10; p++) begin
      for (int i = 0; i < 3; i++) begin
        case (p % 3)
          0: c[i] = near('0, 32'h0010_0000);
          1: c[i] = $urandom;
          default: c[i] = $urandom_range(0, 1) ? CMIN : CMAX;
        endcase
      end
      if (p == 2)
        r = '0;
      else if (p == 5)
        r = RMAX;
      else
        r = RW'($urandom_range(0, 32'h7fff_ffff) >> $urandom_range(0, 24));
      set_sphere(c[0], c[1], c[2], r);
      for (int n = 0; n < 65; n++) begin
        push_query(shaped_query(plan_sphere));
        // hold off mid-phase until every result is back
        if (p == 4 && n == 30) push_drain();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (ops.size() != 0 || in_valid || pending_rel.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
